// ===== rtl/core/btnard_pkg.sv =====
package btnard_pkg;

   // Event kinds carried on the request side in tuser.
   typedef enum logic [1:0] {
      FUNC_POLL   = 2'd0,
      FUNC_UP     = 2'd1,
      FUNC_DOWN   = 2'd2,
      FUNC_REPLAY = 2'd3
   } func_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_REPEAT   = 2'd1,
      CSR_DEBOUNCE = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned MS_W       = 16;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic [MS_W-1:0] REPEAT_RESET   = 16'd200;
   localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd500;

endpackage

// ===== rtl/core/button_autorepeat_debounce_unit.sv =====
// Channel   Dir  Handshake               Payload
// req       in   req_tvalid/req_tready   tdata: now_ms, up_pressed, down_pressed; tuser: func
// rsp       out  rsp_tvalid/rsp_tready   tdata: step_up, step_down, replay_request
// csr       in   csr_we (no wait)        csr_index selects the register, csr_wdata the value
//
// The unit takes one word per cycle while the result side is not stalled, and presents exactly
// one word for each on the result side when the input register hands it to the result register.
// The key and replay state is updated on that same edge, so consecutive words see each
// other's effects in order. A stalled result register holds the input register; the input
// side keeps accepting as long as the input register can move or is empty.
// Reset (synchronous, active high) clears valid flags, key flags and stamps; 200/500 ms.
module button_autorepeat_debounce_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] now_ms, [32] up_pressed, [33] down_pressed, [39:34] zero
   input  logic [btnard_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] func
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] step_up, [1] step_down, [2] replay_request, [7:3] zero
   output logic [btnard_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [btnard_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import btnard_pkg::*;

   // Configuration registers.
   logic            enable_ff,   enable_in;
   logic [MS_W-1:0] repeat_ff,   repeat_in;
   logic [MS_W-1:0] debounce_ff, debounce_in;

   // Input register.
   logic              req_valid_ff, req_valid_in;
   func_type          req_func_ff;
   logic [TIME_W-1:0] req_now_ff;
   logic              req_up_ff;
   logic              req_down_ff;

   // Key and replay state.
   logic              up_held_ff,      up_held_in;
   logic              up_waiting_ff,   up_waiting_in;
   logic [TIME_W-1:0] up_stamp_ff,     up_stamp_in;
   logic              down_held_ff,    down_held_in;
   logic              down_waiting_ff, down_waiting_in;
   logic [TIME_W-1:0] down_stamp_ff,   down_stamp_in;
   logic [TIME_W-1:0] replay_stamp_ff, replay_stamp_in;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic step_up_ff,   step_up_in;
   logic step_down_ff, step_down_in;
   logic replay_ff,    replay_in;

   logic              advance;
   logic [TIME_W-1:0] up_age;
   logic [TIME_W-1:0] down_age;
   logic [TIME_W-1:0] replay_age;

   // The input register moves on when the result register is empty or being drained.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, replay_ff, step_down_ff, step_up_ff};

   // Elapsed times use wrapping 32-bit subtraction.
   assign up_age     = req_now_ff - up_stamp_ff;
   assign down_age   = req_now_ff - down_stamp_ff;
   assign replay_age = req_now_ff - replay_stamp_ff;

   // Configuration writes; an index beyond the list is dropped.
   always_comb begin
      enable_in   = enable_ff;
      repeat_in   = repeat_ff;
      debounce_in = debounce_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:   enable_in   = csr_wdata[0];
            CSR_REPEAT:   repeat_in   = csr_wdata;
            CSR_DEBOUNCE: debounce_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   // Event processing for the word in the input register.
   always_comb begin
      up_held_in      = up_held_ff;
      up_waiting_in   = up_waiting_ff;
      up_stamp_in     = up_stamp_ff;
      down_held_in    = down_held_ff;
      down_waiting_in = down_waiting_ff;
      down_stamp_in   = down_stamp_ff;
      replay_stamp_in = replay_stamp_ff;
      step_up_in      = 1'b0;
      step_down_in    = 1'b0;
      replay_in       = 1'b0;

      if (req_func_ff == FUNC_POLL) begin
         // A held key gives a step at once if still waiting, then once per repeat interval.
         if (up_held_ff) begin
            if (!req_up_ff) begin
               up_held_in    = 1'b0;
               up_waiting_in = 1'b0;
            end else if (up_waiting_ff) begin
               up_waiting_in = 1'b0;
               up_stamp_in   = req_now_ff;
               step_up_in    = 1'b1;
            end else if (up_age >= {{(TIME_W-MS_W){1'b0}}, repeat_ff}) begin
               up_stamp_in = req_now_ff;
               step_up_in  = 1'b1;
            end
         end
         if (down_held_ff) begin
            if (!req_down_ff) begin
               down_held_in    = 1'b0;
               down_waiting_in = 1'b0;
            end else if (down_waiting_ff) begin
               down_waiting_in = 1'b0;
               down_stamp_in   = req_now_ff;
               step_down_in    = 1'b1;
            end else if (down_age >= {{(TIME_W-MS_W){1'b0}}, repeat_ff}) begin
               down_stamp_in = req_now_ff;
               step_down_in  = 1'b1;
            end
         end
      end else if (enable_ff) begin
         // A key edge only drops the held flag of the opposite key; its waiting
         // flag stays but is inert while that key is not held.
         unique case (req_func_ff)
            FUNC_UP: begin
               up_held_in    = 1'b1;
               up_waiting_in = 1'b1;
               up_stamp_in   = req_now_ff;
               down_held_in  = 1'b0;
            end
            FUNC_DOWN: begin
               down_held_in    = 1'b1;
               down_waiting_in = 1'b1;
               down_stamp_in   = req_now_ff;
               up_held_in      = 1'b0;
            end
            FUNC_REPLAY: begin
               if (replay_age >= {{(TIME_W-MS_W){1'b0}}, debounce_ff}) begin
                  replay_stamp_in = req_now_ff;
                  replay_in       = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         repeat_ff       <= REPEAT_RESET;
         debounce_ff     <= DEBOUNCE_RESET;
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         up_held_ff      <= 1'b0;
         up_waiting_ff   <= 1'b0;
         up_stamp_ff     <= '0;
         down_held_ff    <= 1'b0;
         down_waiting_ff <= 1'b0;
         down_stamp_ff   <= '0;
         replay_stamp_ff <= '0;
      end else begin
         enable_ff    <= enable_in;
         repeat_ff    <= repeat_in;
         debounce_ff  <= debounce_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            up_held_ff      <= up_held_in;
            up_waiting_ff   <= up_waiting_in;
            up_stamp_ff     <= up_stamp_in;
            down_held_ff    <= down_held_in;
            down_waiting_ff <= down_waiting_in;
            down_stamp_ff   <= down_stamp_in;
            replay_stamp_ff <= replay_stamp_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_func_ff <= func_type'(req_tuser);
         req_now_ff  <= req_tdata[TIME_W-1:0];
         req_up_ff   <= req_tdata[TIME_W];
         req_down_ff <= req_tdata[TIME_W+1];
      end
      if (advance) begin
         step_up_ff   <= step_up_in;
         step_down_ff <= step_down_in;
         replay_ff    <= replay_in;
      end
   end

   // Only one key can be held at a time.
   a_one_held: assert property (@(posedge clock) disable iff (reset)
      !(up_held_ff && down_held_ff))
      else $error("both keys held");

   // A poll never yields a replay word.
   a_poll_no_replay: assert property (@(posedge clock) disable iff (reset)
      advance && req_func_ff == FUNC_POLL |=> rsp_valid_ff && !replay_ff)
      else $error("replay on a poll");

   // A replay word never carries a step.
   a_replay_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && replay_ff |-> !step_up_ff && !step_down_ff)
      else $error("replay mixed with a step");

   // Edges while disabled leave the key state alone.
   a_disabled_edge: assert property (@(posedge clock) disable iff (reset)
      advance && !enable_ff && req_func_ff != FUNC_POLL |=>
         $stable(up_held_ff) && $stable(down_held_ff) && $stable(replay_stamp_ff))
      else $error("disabled edge changed state");

   // A word that moves on leaves the result register full.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost");

endmodule

// ===== tb/button_autorepeat_debounce_unit_tb.sv =====
module button_autorepeat_debounce_unit_tb;
   import btnard_pkg::*;

   // Index of each key in the predictor's per-key state arrays.
   localparam logic KEY_UP   = 1'b0;
   localparam logic KEY_DOWN = 1'b1;

   // One result word, split into its fields.
   typedef struct packed {
      logic replay_request;
      logic step_down;
      logic step_up;
   } step_word_type;

   // The scoreboard keeps its own copy of the key state and the registers.
   // Every accepted request word is run through the predictor at once, and
   // the expected result is queued. Result words are matched in order.
   class autorepeat_scoreboard;
      logic              enabled;
      logic [MS_W-1:0]   repeat_ms_q;
      logic [MS_W-1:0]   debounce_ms_q;
      logic              key_held[2];
      logic              key_waiting[2];
      logic [TIME_W-1:0] key_stamp[2];
      logic [TIME_W-1:0] replay_stamp;
      step_word_type     due_steps[$];
      int                errors;

      function new();
         enabled                = 1'b0;
         repeat_ms_q            = REPEAT_RESET;
         debounce_ms_q          = DEBOUNCE_RESET;
         replay_stamp           = '0;
         errors                 = 0;
         key_held[KEY_UP]       = 1'b0;
         key_waiting[KEY_UP]    = 1'b0;
         key_stamp[KEY_UP]      = '0;
         key_held[KEY_DOWN]     = 1'b0;
         key_waiting[KEY_DOWN]  = 1'b0;
         key_stamp[KEY_DOWN]    = '0;
      endfunction

      function void configure(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ENABLE:   enabled       = value[0];
            CSR_REPEAT:   repeat_ms_q   = value;
            CSR_DEBOUNCE: debounce_ms_q = value;
            default: ;
         endcase
      endfunction

      // A poll serves one key: a fresh press steps at once, a held key steps
      // again once the repeat interval has gone by, and a release clears it.
      function logic serve_held_key(logic k, logic level, logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] elapsed;
         elapsed = now - key_stamp[k];
         if (!key_held[k])
            return 1'b0;
         if (!level) begin
            key_held[k]    = 1'b0;
            key_waiting[k] = 1'b0;
            return 1'b0;
         end
         if (key_waiting[k]) begin
            key_waiting[k] = 1'b0;
            key_stamp[k]   = now;
            return 1'b1;
         end
         if (elapsed >= TIME_W'(repeat_ms_q)) begin
            key_stamp[k] = now;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(func_type func, logic [TIME_W-1:0] now,
                                 logic up_lvl, logic dn_lvl);
         step_word_type     want;
         logic [TIME_W-1:0] since_replay;
         want = '0;
         since_replay = now - replay_stamp;
         if (func == FUNC_POLL) begin
            want.step_up   = serve_held_key(KEY_UP, up_lvl, now);
            want.step_down = serve_held_key(KEY_DOWN, dn_lvl, now);
         end else if (enabled) begin
            case (func)
               FUNC_UP: begin
                  key_held[KEY_UP]    = 1'b1;
                  key_held[KEY_DOWN]  = 1'b0;
                  key_stamp[KEY_UP]   = now;
                  key_waiting[KEY_UP] = 1'b1;
               end
               FUNC_DOWN: begin
                  key_held[KEY_DOWN]    = 1'b1;
                  key_held[KEY_UP]      = 1'b0;
                  key_stamp[KEY_DOWN]   = now;
                  key_waiting[KEY_DOWN] = 1'b1;
               end
               default: begin
                  if (since_replay >= TIME_W'(debounce_ms_q)) begin
                     replay_stamp        = now;
                     want.replay_request = 1'b1;
                  end
               end
            endcase
         end
         due_steps.push_back(want);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] word);
         step_word_type got;
         step_word_type want;
         got.step_up        = word[0];
         got.step_down      = word[1];
         got.replay_request = word[2];
         if (due_steps.size() == 0) begin
            if (errors < 10)
               $display("ERROR: result word %b arrived with nothing expected", word);
            errors++;
            return;
         end
         want = due_steps.pop_front();
         if (got.step_up !== want.step_up || got.step_down !== want.step_down ||
             got.replay_request !== want.replay_request) begin
            if (errors < 10)
               $display("ERROR: step_up %b/%b step_down %b/%b replay %b/%b (expected/actual)",
                        want.step_up, got.step_up, want.step_down, got.step_down,
                        want.replay_request, got.replay_request);
            errors++;
         end
      endfunction

      function int pending();
         return due_steps.size();
      endfunction
   endclass

   // All block inputs start at known values; reset is high from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   autorepeat_scoreboard sb;

   // Knobs shared by the driving processes. The idle percentages set how
   // often each side sits out a cycle; hold_left forces a long receiver
   // stall so that the pipeline backs up into the request side.
   int unsigned    req_idle_pct = 0;
   int unsigned    rsp_stall_pct = 0;
   int             hold_left = 0;
   int unsigned    cur_repeat = 32'(REPEAT_RESET);
   int unsigned    cur_debounce = 32'(DEBOUNCE_RESET);
   logic [TIME_W-1:0] now_cur = '0;
   logic           focus_up = 1'b1;

   button_autorepeat_debounce_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: every cycle it either takes the result word or stalls. Values
   // read right after the edge are the ones the block sampled at that edge,
   // since every signal here changes through the nonblocking update region.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Result monitor: each accepted word goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // Offers one request word, after a random number of idle cycles, and
   // keeps it up until the block takes it. The prediction is made at the
   // accepting edge so that the expected queue is never behind the block.
   task automatic send_word(func_type func, logic [TIME_W-1:0] now,
                            logic up_lvl, logic dn_lvl);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'b0, dn_lvl, up_lvl, now};
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      sb.note_request(func, now, up_lvl, dn_lvl);
   endtask

   // Stops offering words and waits until every expected result has come
   // back. Every word gives exactly one result, so the block is idle then.
   task automatic drain();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   // The register is written at the edge where csr_we is high; a further edge keeps csr_we from
   // being lowered and raised in the same time step on back-to-back writes.
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.configure(idx, value);
      @(posedge clock);
   endtask

   task automatic set_mode(logic [CSR_DATA_W-1:0] en_word, logic [MS_W-1:0] rep,
                           logic [MS_W-1:0] deb);
      write_csr(CSR_ENABLE, en_word);
      write_csr(CSR_REPEAT, rep);
      write_csr(CSR_DEBOUNCE, deb);
      cur_repeat   = 32'(rep);
      cur_debounce = 32'(deb);
   endtask

   // Random traffic. Time moves forward in steps scaled to the current
   // repeat interval, with occasional long jumps and a few arbitrary ones.
   // Polls mostly hold down the key that was pressed last, so the repeat
   // logic gets exercised, and now and then release it.
   task automatic random_burst(int count);
      int unsigned roll;
      func_type    func;
      logic        up_lvl;
      logic        dn_lvl;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            now_cur = $urandom();
         else if (roll < 12)
            now_cur = now_cur + $urandom_range(0, cur_repeat + cur_debounce + 2);
         else
            now_cur = now_cur + $urandom_range(0, (cur_repeat >> 2) + 4);
         roll   = $urandom_range(0, 99);
         up_lvl = 1'($urandom_range(0, 1));
         dn_lvl = 1'($urandom_range(0, 1));
         if (roll < 11) begin
            func     = FUNC_UP;
            focus_up = 1'b1;
         end else if (roll < 22) begin
            func     = FUNC_DOWN;
            focus_up = 1'b0;
         end else if (roll < 32) begin
            func = FUNC_REPLAY;
         end else begin
            func   = FUNC_POLL;
            up_lvl = ($urandom_range(0, 99) < (focus_up ? 88 : 25));
            dn_lvl = ($urandom_range(0, 99) < (focus_up ? 25 : 88));
         end
         send_word(func, now_cur, up_lvl, dn_lvl);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] en_word;
      logic [MS_W-1:0]       rep_val;
      logic [MS_W-1:0]       deb_val;
      int                    k;

      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the edges are disabled: key and replay edges change
      // nothing, and a poll finds no key held.
      send_word(FUNC_UP, 32'd10, 1'b1, 1'b1);
      send_word(FUNC_REPLAY, 32'd600, 1'b0, 1'b0);
      send_word(FUNC_POLL, 32'd20, 1'b1, 1'b1);
      drain();

      // Enable with junk in the upper bits; repeat and debounce keep their
      // reset values of 200 and 500 ms.
      write_csr(CSR_ENABLE, 16'hABC1);

      // Replay shortly after reset is rejected, since the replay stamp
      // starts at zero. After that the window is measured from each accept.
      send_word(FUNC_REPLAY, 32'd100, 1'b0, 1'b0);
      send_word(FUNC_REPLAY, 32'd500, 1'b0, 1'b0);
      send_word(FUNC_REPLAY, 32'd999, 1'b0, 1'b0);
      send_word(FUNC_REPLAY, 32'd1000, 1'b0, 1'b0);

      // Up press with both key levels set; the levels mean nothing on an
      // edge. The first poll steps at once, the next step waits 200 ms.
      send_word(FUNC_UP, 32'd2000, 1'b1, 1'b1);
      send_word(FUNC_POLL, 32'd2001, 1'b1, 1'b0);
      send_word(FUNC_POLL, 32'd2100, 1'b1, 1'b0);
      send_word(FUNC_POLL, 32'd2201, 1'b1, 1'b0);

      // A down press takes the hold away from up.
      send_word(FUNC_DOWN, 32'd2300, 1'b0, 1'b0);
      send_word(FUNC_POLL, 32'd2301, 1'b1, 1'b1);

      // Up pressed and at once cancelled by down: up keeps its waiting flag
      // but is not held, so the poll steps down only. Then both released.
      send_word(FUNC_UP, 32'd2400, 1'b0, 1'b0);
      send_word(FUNC_DOWN, 32'd2401, 1'b0, 1'b0);
      send_word(FUNC_POLL, 32'd2402, 1'b1, 1'b1);
      send_word(FUNC_POLL, 32'd2403, 1'b0, 1'b0);

      // Hold across the wrap of the millisecond counter.
      send_word(FUNC_UP, 32'hFFFF_FF00, 1'b0, 1'b1);
      send_word(FUNC_POLL, 32'hFFFF_FF00, 1'b1, 1'b0);
      send_word(FUNC_POLL, 32'h0000_0010, 1'b1, 1'b0);
      send_word(FUNC_REPLAY, 32'hFFFF_FFFF, 1'b1, 1'b1);
      drain();

      // Zero repeat interval and zero debounce window: a held key steps on
      // every poll, and every replay edge is accepted. A write to the unused
      // index must not disturb anything.
      write_csr(CSR_REPEAT, 16'h0000);
      write_csr(CSR_DEBOUNCE, 16'h0000);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_word(FUNC_UP, 32'd5000, 1'b0, 1'b0);
      send_word(FUNC_POLL, 32'd5000, 1'b1, 1'b0);
      send_word(FUNC_POLL, 32'd5000, 1'b1, 1'b0);
      send_word(FUNC_REPLAY, 32'd5000, 1'b0, 1'b0);
      send_word(FUNC_REPLAY, 32'd5000, 1'b0, 1'b0);
      drain();

      // Disabled again: the down edge is ignored, but the up key that is
      // still held keeps stepping on polls.
      write_csr(CSR_ENABLE, 16'hFFFE);
      send_word(FUNC_DOWN, 32'd5002, 1'b1, 1'b1);
      send_word(FUNC_POLL, 32'd5003, 1'b1, 1'b1);
      now_cur = 32'd5003;

      // Random part: four idling patterns, each with two register settings.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin req_idle_pct = 13; rsp_stall_pct = 13; end
         endcase
         for (int s = 0; s < 2; s++) begin
            k = ph * 2 + s;
            case (k)
               0: begin rep_val = 16'd1;    deb_val = 16'd1;    end
               1: begin rep_val = 16'hFFFF; deb_val = 16'hFFFF; end
               2: begin rep_val = 16'd0;    deb_val = 16'd0;    end
               5: begin rep_val = 16'($urandom()); deb_val = 16'($urandom()); end
               default: begin
                  rep_val = 16'($urandom_range(1, 400));
                  deb_val = 16'($urandom_range(1, 1500));
               end
            endcase
            en_word    = 16'($urandom());
            en_word[0] = (k != 3);
            drain();
            set_mode(en_word, rep_val, deb_val);
            if (k == 4)
               write_csr(CSR_UNUSED, 16'($urandom()));
            // With no idling on either side, a long receiver stall lets the
            // block fill up and push back on the request side.
            if (k == 0)
               hold_left = 48;
            random_burst(66);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== button_autorepeat_debounce_unit.f =====
rtl/core/btnard_pkg.sv
rtl/core/button_autorepeat_debounce_unit.sv
tb/button_autorepeat_debounce_unit_tb.sv
